@@ rtl/ad_pkg.sv @@
// Arithmetic decoder package: action codes, state, result and divider-select enums and
// the command/status structs shared between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package ad_pkg;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_DECODE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_MUL,
    ST_SCALE_DIV,
    ST_SEARCH_ADDR,
    ST_SEARCH_CMP,
    ST_NARROW_HI_MUL,
    ST_NARROW_HI_DIV,
    ST_NARROW_LO_MUL,
    ST_NARROW_LO_DIV,
    ST_RENORM_INIT,
    ST_RENORM,
    ST_OUT
  } ad_state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_START,
    RES_HALTED,
    RES_DONE
  } ad_res_e;

  typedef enum logic [1:0] {
    DIV_SCALE,
    DIV_HI,
    DIV_LO
  } ad_div_e;

  typedef struct packed {
    logic    capture;     // latch input payload
    logic    tab_write;   // write table entry
    logic    do_start;    // restart interval
    logic    mul_go;      // run one multiply stage
    ad_div_e mul_sel;
    logic    div_start;   // launch divider
    logic    div_step;    // one divider iteration
    logic    search_clr;  // reset search index
    logic    search_rd;   // issue table read
    logic    search_inc;  // advance search index
    logic    latch_sym;   // keep matched entry
    logic    commit_hi;
    logic    commit_lo;
    logic    renorm_clr;
    logic    renorm_step;
    logic    commit_dec;  // store interval, bump count
    logic    set_halt;
    logic    res_load;    // load output register
    ad_res_e res_kind;
    logic    res_sym;     // result is a decoded symbol
  } ad_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       halted;
    logic       done;       // symbols_decoded >= T
    logic       div_busy;
    logic       match;
    logic       search_last;
    logic       renorm_end;
  } ad_sts_t;

endpackage

@@ rtl/arithmetic_decoder_core.sv @@
// Arithmetic decoder top level: controller plus datapath, total_count register
// and result valid flag. Depends on ad_pkg, ad_ctrl, ad_dpath.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid_i/in_ready_o | action, entry_symbol, cum_low/high, window
//   result   | out_valid_o/out_ready_i | symbol_out, bits_used, error/done flags
//   config   | cfg_valid_i/cfg_ready_o | total_count
//
// A decode runs a scale multiply and division, a serial search of the table entry by
// entry, a multiply and division each for the new high and low bound, and
// renormalization; the serial table search and the one-bit-a-cycle divider bound
// its length. Input is taken only while idle; a result waits in the output
// register while the next request is captured. Reset clears state, table valid
// bits and total_count (to 1).
`timescale 1ns / 1ps
module arithmetic_decoder_core #(
  parameter int CODE_BITS    = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  entry_symbol_i,
  input  logic [13:0] cum_low_i,
  input  logic [13:0] cum_high_i,
  input  logic [15:0] code_window_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  symbol_out_o,
  output logic [4:0]  bits_used_o,
  output logic        error_flag_o,
  output logic        done_flag_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i
);
  import ad_pkg::*;

  ad_cmd_t     cmd;
  ad_sts_t     sts;
  logic [13:0] total_q;
  logic        ovld_q;
  logic        res_free;

  assign cfg_ready_o = 1'b1;
  assign res_free    = !ovld_q || out_ready_i;
  assign out_valid_o = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 14'd1;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if (cmd.res_load) begin
        ovld_q <= 1'b1;
      end else if (out_ready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  ad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .res_free_i (res_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ad_dpath #(
    .CODE_BITS    (CODE_BITS),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .total_count_i  (total_q),
    .action_i       (action_i),
    .entry_symbol_i (entry_symbol_i),
    .cum_low_i      (cum_low_i),
    .cum_high_i     (cum_high_i),
    .code_window_i  (code_window_i),
    .symbol_out_o   (symbol_out_o),
    .bits_used_o    (bits_used_o),
    .error_flag_o   (error_flag_o),
    .done_flag_o    (done_flag_o)
  );

endmodule

@@ rtl/ad_ctrl.sv @@
// Arithmetic decoder controller: sequences one request at a time, a load, a start or a
// decode through scale, search, narrow and renormalize. Depends on ad_pkg.
`timescale 1ns / 1ps
module ad_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            res_free_i,
  input  ad_pkg::ad_sts_t sts_i,
  output ad_pkg::ad_cmd_t cmd_o
);
  import ad_pkg::*;

  ad_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel  = DIV_SCALE;
    cmd_o.res_kind = RES_ZERO;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // captured request: decide what to do with it
        if (sts_i.action == ACT_DECODE && !sts_i.halted && !sts_i.done) begin
          state_d = ST_SCALE_MUL;
        end else if (res_free_i) begin
          cmd_o.res_load = 1'b1;
          if (sts_i.action == ACT_LOAD) begin
            cmd_o.tab_write = 1'b1;
          end else if (sts_i.action == ACT_START) begin
            cmd_o.do_start = 1'b1;
            cmd_o.res_kind = RES_START;
          end else if (sts_i.action == ACT_DECODE) begin
            cmd_o.res_kind = sts_i.halted ? RES_HALTED : RES_DONE;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCALE_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = DIV_SCALE;
        state_d = ST_SCALE_DIV;
      end
      ST_SCALE_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.search_clr = 1'b1;
        state_d = ST_SEARCH_ADDR;
      end
      ST_SEARCH_ADDR: begin
        if (sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.search_rd = 1'b1;
          state_d = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.latch_sym = 1'b1;
          state_d = ST_NARROW_HI_MUL;
        end else if (sts_i.search_last) begin
          if (res_free_i) begin
            cmd_o.set_halt = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_HALTED;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.search_inc = 1'b1;
          state_d = ST_SEARCH_ADDR;
        end
      end
      ST_NARROW_HI_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = DIV_HI;
        state_d = ST_NARROW_HI_DIV;
      end
      ST_NARROW_HI_DIV: begin
        cmd_o.mul_sel = DIV_HI;
        if (!sts_i.div_busy) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_NARROW_LO_MUL;
        end
      end
      ST_NARROW_LO_MUL: begin
        if (sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.commit_hi = 1'b1;
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = DIV_LO;
          state_d = ST_NARROW_LO_DIV;
        end
      end
      ST_NARROW_LO_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.mul_sel = DIV_LO;
        state_d = ST_RENORM_INIT;
      end
      ST_RENORM_INIT: begin
        // take the new low bound only once the quotient is complete
        if (sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.commit_lo  = 1'b1;
          cmd_o.renorm_clr = 1'b1;
          state_d = ST_RENORM;
        end
      end
      ST_RENORM: begin
        if (!sts_i.renorm_end) begin
          cmd_o.renorm_step = 1'b1;
        end else if (res_free_i) begin
          cmd_o.commit_dec = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_sym  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/ad_dpath.sv @@
// Arithmetic decoder datapath: state registers, symbol table memory, multiplier,
// shared restoring divider and renormalization shifter. Depends on ad_pkg.
`timescale 1ns / 1ps
module ad_dpath #(
  parameter int CODE_BITS    = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ad_pkg::ad_cmd_t cmd_i,
  output ad_pkg::ad_sts_t sts_o,
  input  logic [13:0]     total_count_i,
  input  logic [1:0]      action_i,
  input  logic [7:0]      entry_symbol_i,
  input  logic [13:0]     cum_low_i,
  input  logic [13:0]     cum_high_i,
  input  logic [15:0]     code_window_i,
  output logic [7:0]      symbol_out_o,
  output logic [4:0]      bits_used_o,
  output logic            error_flag_o,
  output logic            done_flag_o
);
  import ad_pkg::*;

  localparam int CB   = CODE_BITS;
  localparam int SW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int PW   = CB + 15;            // product width
  localparam int DW   = PW;                 // dividend width
  localparam int QCW  = $clog2(DW + 1);
  localparam int RCW  = $clog2(CB + 1);
  localparam logic [CB-1:0] MAXV = {CB{1'b1}};
  localparam logic [CB-1:0] HALF = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] QUARTER = {2'b01, {(CB-2){1'b0}}};
  localparam logic [CB-1:0] THREE_Q = {2'b11, {(CB-2){1'b0}}};

  // captured request
  logic [1:0]  act_q;
  logic [7:0]  sym_in_q;
  logic [13:0] cl_q, ch_q;
  logic [15:0] win_q;

  // decoder state
  logic [CB-1:0] low_q, high_q, val_q;
  logic [13:0]   count_q;
  logic          halted_q;

  // table: valid bits plus memory of {low, high}
  logic [27:0]   tab_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tab_vld_q;
  logic [27:0]   tab_rd_q;
  logic          tab_rd_vld_q;
  logic [SW:0]   idx_q;
  logic [SW-1:0] sym_q;
  logic [13:0]   sl_q, sh_q;

  logic [13:0]   t_eff;
  logic [CB:0]   range_w;
  logic [PW-1:0] prod_q;
  logic [CB:0]   mul_a;
  logic [13:0]   mul_b;

  logic [DW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvd_q;
  logic [QCW-1:0] dcnt_q;
  logic          dbusy_q;
  logic [DW:0]   rem_sh;

  logic [CB-1:0] nlo_q, nhi_q, nval_q;
  logic [RCW-1:0] rcnt_q;
  logic [4:0]    used_q;
  logic          rstop_q;
  logic [CB-1:0] l2, h2, v2;
  logic          rcase;

  logic [13:0]   scaled;

  assign t_eff   = (total_count_i == 14'd0) ? 14'd1 : total_count_i;
  assign range_w = {1'b0, high_q - low_q} + {{CB{1'b0}}, 1'b1};

  // multiplier operand select
  always_comb begin
    mul_a = range_w;
    mul_b = sh_q;
    case (cmd_i.mul_sel)
      DIV_SCALE: begin
        mul_a = {1'b0, val_q - low_q} + {{CB{1'b0}}, 1'b1};
        mul_b = t_eff;
      end
      DIV_HI:  mul_b = sh_q;
      DIV_LO:  mul_b = sl_q;
      default: mul_b = sl_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      prod_q <= PW'(mul_a * mul_b);
    end
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_q, dvd_q[DW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= QCW'(DW);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == QCW'(1)) begin
        dbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      // scale divides prod-1 by range; hi divides prod-1 by T; lo divides prod by T
      dvd_q <= (cmd_i.mul_sel == DIV_LO) ? prod_q : prod_q - PW'(1);
      rem_q <= '0;
      quo_q <= (cmd_i.mul_sel == DIV_SCALE) ? {{(DW-CB-1){1'b0}}, range_w}
                                           : {{(DW-14){1'b0}}, t_eff};
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, quo_q}) begin
        rem_q <= DW'(rem_sh - {1'b0, quo_q});
        dvd_q <= {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= DW'(rem_sh);
        dvd_q <= {dvd_q[DW-2:0], 1'b0};
      end
    end
  end

  // quotient bits accumulate in dvd_q's low end; dvd_q is the quotient after DW steps
  assign scaled = (dvd_q[DW-1:14] != '0) ? 14'h3FFF : dvd_q[13:0];
  logic scaled_big;
  assign scaled_big = (dvd_q[DW-1:14] != '0);

  // table write and search read
  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_write && {1'b0, sym_in_q} < 9'(SYMBOL_COUNT)) begin
      tab_mem[sym_in_q[SW-1:0]] <= {cl_q, ch_q};
    end
    if (cmd_i.search_rd) begin
      tab_rd_q <= tab_mem[idx_q[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_vld_q    <= '0;
      tab_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.tab_write && {1'b0, sym_in_q} < 9'(SYMBOL_COUNT)) begin
        tab_vld_q[sym_in_q[SW-1:0]] <= 1'b1;
      end
      if (cmd_i.search_rd) begin
        tab_rd_vld_q <= tab_vld_q[idx_q[SW-1:0]];
      end
    end
  end

  logic [13:0] rd_lo, rd_hi;
  assign rd_lo = tab_rd_vld_q ? tab_rd_q[27:14] : 14'd0;
  assign rd_hi = tab_rd_vld_q ? tab_rd_q[13:0]  : 14'd0;

  assign sts_o.match = !scaled_big && (scaled >= rd_lo) && (scaled < rd_hi);
  assign sts_o.search_last = (idx_q == (SW+1)'(SYMBOL_COUNT - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_clr) begin
      idx_q <= '0;
    end else if (cmd_i.search_inc) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.latch_sym) begin
      sym_q <= idx_q[SW-1:0];
      sl_q  <= rd_lo;
      sh_q  <= rd_hi;
    end
  end

  // renormalization, one shift a cycle
  always_comb begin
    rcase = 1'b1;
    l2 = nlo_q;
    h2 = nhi_q;
    v2 = nval_q;
    if (nhi_q < HALF) begin
      rcase = 1'b1;
    end else if (nlo_q >= HALF) begin
      l2 = nlo_q - HALF;
      h2 = nhi_q - HALF;
      v2 = nval_q - HALF;
    end else if (nlo_q >= QUARTER && nhi_q < THREE_Q) begin
      l2 = nlo_q - QUARTER;
      h2 = nhi_q - QUARTER;
      v2 = nval_q - QUARTER;
    end else begin
      rcase = 1'b0;
    end
  end

  logic wbit;
  assign wbit = (used_q[4]) ? 1'b0 : win_q[4'(15 - used_q[3:0])];
  assign sts_o.renorm_end = rstop_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.renorm_clr) begin
      rcnt_q  <= '0;
      used_q  <= '0;
      rstop_q <= 1'b0;
      nval_q  <= val_q;
    end else if (cmd_i.renorm_step) begin
      if (!rcase || rcnt_q == RCW'(CB)) begin
        rstop_q <= 1'b1;
      end else begin
        nlo_q  <= {l2[CB-2:0], 1'b0};
        nhi_q  <= {h2[CB-2:0], 1'b1};
        nval_q <= {v2[CB-2:0], wbit};
        rcnt_q <= rcnt_q + 1'b1;
        if (!used_q[4]) begin
          used_q <= used_q + 5'd1;
        end
        if (rcnt_q == RCW'(CB - 1)) begin
          rstop_q <= 1'b1;
        end
      end
    end
    if (cmd_i.commit_hi) begin
      nhi_q <= low_q + dvd_q[CB-1:0];
    end
    if (cmd_i.commit_lo) begin
      nlo_q <= low_q + dvd_q[CB-1:0];
    end
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= action_i;
      sym_in_q <= entry_symbol_i;
      cl_q     <= cum_low_i;
      ch_q     <= cum_high_i;
      win_q    <= code_window_i;
    end
  end

  // decoder state
  logic [CB-1:0] start_val;
  always_comb begin
    if (CB <= 16) begin
      start_val = CB'(win_q >> (16 - CB));
    end else begin
      start_val = CB'({win_q, {((CB > 16) ? CB - 16 : 1){1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= MAXV;
      val_q    <= '0;
      count_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      if (cmd_i.do_start) begin
        low_q    <= '0;
        high_q   <= MAXV;
        val_q    <= start_val;
        count_q  <= '0;
        halted_q <= 1'b0;
      end
      if (cmd_i.set_halt) begin
        halted_q <= 1'b1;
      end
      if (cmd_i.commit_dec) begin
        low_q   <= nlo_q;
        high_q  <= nhi_q;
        val_q   <= nval_q;
        count_q <= count_q + 14'd1;
      end
    end
  end

  assign sts_o.action   = act_q;
  assign sts_o.halted   = halted_q;
  assign sts_o.done     = (count_q >= t_eff);
  assign sts_o.div_busy = dbusy_q;

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (cmd_i.res_sym) begin
        symbol_out_o <= 8'(sym_q);
        bits_used_o  <= used_q;
        error_flag_o <= 1'b0;
        done_flag_o  <= ((count_q + 14'd1) >= t_eff);
      end else begin
        symbol_out_o <= '0;
        bits_used_o  <= (cmd_i.res_kind == RES_START) ?
                        ((CB > 16) ? 5'd16 : 5'(CB)) : 5'd0;
        error_flag_o <= (cmd_i.res_kind == RES_HALTED);
        done_flag_o  <= (cmd_i.res_kind == RES_DONE);
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for arithmetic_decoder_core: random and directed requests
// are scored against a cycle-free decoder model. Depends on ad_pkg and the core.
`timescale 1ns / 1ps
module tb_top;
  import ad_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint unsigned CODE_MAX = 64'hFFFF;
  localparam longint unsigned HALF_PT = 64'h8000;
  localparam longint unsigned QTR_PT = 64'h4000;
  localparam longint unsigned TQTR_PT = 64'hC000;
  localparam int DRAIN_CYCLES = 700;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEM_GOAL = 850;

  typedef struct packed {
    logic [7:0] sym;
    logic [4:0] bits;
    logic       err;
    logic       done;
  } dec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [7:0]  entry_symbol = '0;
  logic [13:0] cum_low = '0;
  logic [13:0] cum_high = '0;
  logic [15:0] code_window = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  symbol_out;
  logic [4:0]  bits_used;
  logic        error_flag;
  logic        done_flag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data = '0;

  arithmetic_decoder_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .entry_symbol_i(entry_symbol),
    .cum_low_i(cum_low), .cum_high_i(cum_high), .code_window_i(code_window),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .symbol_out_o(symbol_out), .bits_used_o(bits_used),
    .error_flag_o(error_flag), .done_flag_o(done_flag),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder model state
  logic [13:0]     total_reg = 14'd1;
  longint unsigned iv_low = 0, iv_high = CODE_MAX, code_val = 0, n_decoded = 0;
  bit              halted = 1'b0;
  logic [13:0]     freq_lo [256];
  logic [13:0]     freq_hi [256];

  dec_result_t pending_results[$];
  int  mismatches = 0;
  int  items_sent = 0;
  bit  calm = 1'b0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;

  function automatic dec_result_t decode_symbol(logic [1:0] act, logic [7:0] es,
      logic [13:0] cl, logic [13:0] ch, logic [15:0] win);
    dec_result_t r;
    longint unsigned t, rng, scaled, lo, hi, v;
    int k, sh, used, hit;
    r = '0;
    case (act)
      ACT_LOAD: begin
        freq_lo[es] = cl;
        freq_hi[es] = ch;
        return r;
      end
      ACT_START: begin
        code_val = win;
        iv_low = 0;
        iv_high = CODE_MAX;
        n_decoded = 0;
        halted = 1'b0;
        r.bits = 5'd16;
        return r;
      end
      ACT_DECODE: ;
      default: return r;
    endcase
    t = (total_reg == 0) ? 1 : total_reg;
    if (halted) begin
      r.err = 1'b1;
      return r;
    end
    if (n_decoded >= t) begin
      r.done = 1'b1;
      return r;
    end
    lo = iv_low;
    hi = iv_high;
    v = code_val;
    rng = ((hi - lo) & CODE_MAX) + 1;
    scaled = ((((v - lo) & CODE_MAX) + 1) * t - 1) / rng;
    hit = -1;
    for (k = 0; k < 256; k++) begin
      if (hit < 0 && scaled >= freq_lo[k] && scaled < freq_hi[k]) hit = k;
    end
    if (hit < 0) begin
      halted = 1'b1;
      r.err = 1'b1;
      return r;
    end
    hi = (lo + (rng * freq_hi[hit] - 1) / t) & CODE_MAX;
    lo = (lo + (rng * freq_lo[hit]) / t) & CODE_MAX;
    used = 0;
    for (sh = 0; sh < 16; sh++) begin
      if (hi < HALF_PT) begin
      end else if (lo >= HALF_PT) begin
        v = (v - HALF_PT) & CODE_MAX;
        lo -= HALF_PT;
        hi -= HALF_PT;
      end else if (lo >= QTR_PT && hi < TQTR_PT) begin
        v = (v - QTR_PT) & CODE_MAX;
        lo -= QTR_PT;
        hi -= QTR_PT;
      end else begin
        break;
      end
      lo = (lo << 1) & CODE_MAX;
      hi = ((hi << 1) & CODE_MAX) | 1;
      v = ((v << 1) & CODE_MAX) | ((used < 16) ? win[15 - used] : 1'b0);
      if (used < 16) used++;
    end
    iv_low = lo;
    iv_high = hi;
    code_val = v;
    n_decoded++;
    r.sym = hit[7:0];
    r.bits = used[4:0];
    r.done = (n_decoded >= t);
    return r;
  endfunction

  // leaves valid high on return so a following request goes out back to back
  task automatic send_request(logic [1:0] act, logic [7:0] es, logic [13:0] cl,
      logic [13:0] ch, logic [15:0] win);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    entry_symbol <= es;
    cum_low <= cl;
    cum_high <= ch;
    code_window <= win;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(decode_symbol(act, es, cl, ch, win));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(logic [13:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    total_reg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    // empty table after reset: search fails and the block stays halted until the next start
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'h1234);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'h0000);
    send_request(ACT_UNUSED, 8'hFF, 14'h3FFF, 14'h3FFF, 16'hFFFF);
    send_request(ACT_LOAD, 8'd255, 14'd0, 14'd1, 16'h0000);
    send_request(ACT_START, 8'd0, 14'd0, 14'd0, 16'hFFFF);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'h0000);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'hFFFF);
    send_request(ACT_LOAD, 8'd0, 14'h3FFF, 14'h3FFF, 16'h0000);
    send_request(ACT_START, 8'd0, 14'd0, 14'd0, 16'h0000);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'hA5A5);
  endtask

  task automatic test_total_extremes();
    write_total(14'd0);
    send_request(ACT_START, 8'd0, 14'd0, 14'd0, 16'h8001);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'h5555);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'h5555);
    write_total(14'h3FFF);
    send_request(ACT_LOAD, 8'd7, 14'd0, 14'h3FFF, 16'h0000);
    send_request(ACT_LOAD, 8'd255, 14'd0, 14'd0, 16'h0000);
    send_request(ACT_START, 8'd0, 14'd0, 14'd0, 16'h7FFE);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'h0000);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'hFFFF);
    send_request(ACT_DECODE, 8'd0, 14'd0, 14'd0, 16'h3C3C);
  endtask

  task automatic test_random_messages();
    int msg, n, i, k, t, base, cut, decodes;
    logic [7:0] syms [8];
    msg = 0;
    while (items_sent < ITEM_GOAL) begin
      calm = (msg >= 3 && msg <= 5);
      if ($urandom_range(7) == 0) t = (msg == 1) ? 16383 : $urandom_range(16383, 1);
      else t = $urandom_range(40, 1);
      write_total(t[13:0]);
      n = $urandom_range((t < 8) ? t : 8, 1);
      // contiguous partition of [0, t) over n random symbols
      base = 0;
      for (i = 0; i < n; i++) begin
        syms[i] = 8'($urandom_range(255));
        cut = (i == n - 1) ? t : base + $urandom_range(t - base - (n - 1 - i), 1);
        send_request(ACT_LOAD, syms[i], base[13:0], cut[13:0], 16'($urandom));
        base = cut;
      end
      // occasionally punch a hole so the search can fail
      if ($urandom_range(9) == 0)
        send_request(ACT_LOAD, syms[$urandom_range(n - 1)], 14'd0, 14'd0,
                     16'($urandom));
      send_request(ACT_START, 8'($urandom), 14'($urandom), 14'($urandom),
                   16'($urandom));
      if (msg == 0) hold_req++;
      decodes = ((t < 30) ? t : 30) + $urandom_range(2);
      for (k = 0; k < decodes; k++) begin
        if ($urandom_range(9) == 0)
          send_request(2'($urandom_range(3)), 8'($urandom), 14'($urandom),
                       14'($urandom), 16'($urandom));
        else
          send_request(ACT_DECODE, 8'($urandom), 14'($urandom), 14'($urandom),
                       16'($urandom));
      end
      msg++;
    end
    calm = 1'b0;
  endtask

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result sym=%0d bits=%0d err=%b done=%b",
                                       symbol_out, bits_used, error_flag, done_flag);
      end else begin
        dec_result_t exp_r;
        exp_r = pending_results.pop_front();
        if (exp_r != {symbol_out, bits_used, error_flag, done_flag}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sym=%0d bits=%0d err=%b done=%b, got %0d %0d %b %b",
                     exp_r.sym, exp_r.bits, exp_r.err, exp_r.done,
                     symbol_out, bits_used, error_flag, done_flag);
        end
      end
    end
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      freq_lo[i] = '0;
      freq_hi[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_total_extremes();
    test_random_messages();
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ad_pkg.sv
rtl/ad_ctrl.sv
rtl/ad_dpath.sv
rtl/arithmetic_decoder_core.sv
dv/tb_top.sv
